// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared types, codes and helpers for the complex arithmetic unit
// Opcodes, divider cell lane step and 32-bit saturation.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // quotient bits produced by the divider chain, one per cell
    localparam int QBITS = 33;

    typedef struct packed {
        logic [1:0]  op;
        logic        dz;
        logic        pov_re;
        logic        pov_im;
        logic        neg_re;
        logic        neg_im;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        ov;
    } t_meta;

    typedef struct packed {
        logic [63:0]      rem;
        logic [QBITS-1:0] low;
        logic [QBITS-1:0] quo;
    } t_lane;

    typedef struct packed {
        logic [31:0] val;
        logic        ov;
    } t_sat;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        ov;
        logic        dz;
    } t_result;

    // one restoring division step: shift in the next dividend bit
    function automatic t_lane div_step(input t_lane l, input logic [63:0] den);
        t_lane       n;
        logic [64:0] rs;
        logic        ge;
        rs    = {l.rem, l.low[QBITS-1]};
        ge    = rs >= {1'b0, den};
        n.rem = ge ? 64'(rs - {1'b0, den}) : rs[63:0];
        n.low = {l.low[QBITS-2:0], 1'b0};
        n.quo = {l.quo[QBITS-2:0], ge};
        return n;
    endfunction

    function automatic t_sat sat66(input logic signed [65:0] v);
        t_sat s;
        if (v > 66'sd2147483647) begin
            s.val = 32'h7FFF_FFFF;
            s.ov  = 1'b1;
        end else if (v < -66'sd2147483648) begin
            s.val = 32'h8000_0000;
            s.ov  = 1'b1;
        end else begin
            s.val = v[31:0];
            s.ov  = 1'b0;
        end
        return s;
    endfunction

    // quotient magnitude to signed Q16.16; pov marks a quotient beyond QBITS
    function automatic t_sat qsat(input logic neg, input logic pov,
                                  input logic [QBITS-1:0] q);
        t_sat s;
        if (!neg) begin
            if (pov || q > 33'h0_7FFF_FFFF) begin
                s.val = 32'h7FFF_FFFF;
                s.ov  = 1'b1;
            end else begin
                s.val = q[31:0];
                s.ov  = 1'b0;
            end
        end else begin
            if (pov || q > 33'h0_8000_0000) begin
                s.val = 32'h8000_0000;
                s.ov  = 1'b1;
            end else begin
                s.val = 32'(~q[31:0] + 32'd1);
                s.ov  = 1'b0;
            end
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front: product and sum stages of the complex arithmetic unit
// Three stages: cross products, sums, then scaling/saturation or divider setup.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [1:0]          i_opcode,
    input  logic signed [31:0]  i_a_re,
    input  logic signed [31:0]  i_a_im,
    input  logic signed [31:0]  i_b_re,
    input  logic signed [31:0]  i_b_im,
    output logic                o_valid,
    output cau_pkg::t_meta      o_meta,
    output logic [63:0]         o_den,
    output cau_pkg::t_lane      o_re,
    output cau_pkg::t_lane      o_im
);
    import cau_pkg::*;

    localparam int NW = 64 + FRAC_BITS;

    // stage 1
    logic               r1_v;
    logic [1:0]         r1_op;
    logic signed [63:0] r1_prr, r1_pii, r1_pri, r1_pir, r1_brr, r1_bii;
    logic signed [32:0] r1_sre, r1_sim;

    // stage 2
    logic               r2_v;
    logic [1:0]         r2_op;
    logic signed [65:0] r2_re, r2_im;
    logic [63:0]        r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            o_valid <= r2_v;
        end
    end

    logic signed [32:0] n_sre, n_sim;
    always_comb begin
        if (i_opcode == OP_SUB) begin
            n_sre = 33'(i_a_re) - 33'(i_b_re);
            n_sim = 33'(i_a_im) - 33'(i_b_im);
        end else begin
            n_sre = 33'(i_a_re) + 33'(i_b_re);
            n_sim = 33'(i_a_im) + 33'(i_b_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op  <= i_opcode;
            r1_prr <= 64'(i_a_re) * 64'(i_b_re);
            r1_pii <= 64'(i_a_im) * 64'(i_b_im);
            r1_pri <= 64'(i_a_re) * 64'(i_b_im);
            r1_pir <= 64'(i_a_im) * 64'(i_b_re);
            r1_brr <= 64'(i_b_re) * 64'(i_b_re);
            r1_bii <= 64'(i_b_im) * 64'(i_b_im);
            r1_sre <= n_sre;
            r1_sim <= n_sim;
        end
    end

    logic signed [65:0] n_re, n_im;
    always_comb begin
        case (r1_op)
            OP_MUL: begin
                n_re = 66'(r1_prr) - 66'(r1_pii);
                n_im = 66'(r1_pri) + 66'(r1_pir);
            end
            OP_DIV: begin
                n_re = 66'(r1_prr) + 66'(r1_pii);
                n_im = 66'(r1_pir) - 66'(r1_pri);
            end
            default: begin
                n_re = 66'(r1_sre);
                n_im = 66'(r1_sim);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_op  <= r1_op;
            r2_re  <= n_re;
            r2_im  <= n_im;
            r2_den <= 64'(r1_brr) + 64'(r1_bii);
        end
    end

    // stage 3: finish add/sub/mul, set up the divider lanes
    t_sat               s_re, s_im;
    logic signed [65:0] v_re, v_im;
    logic [63:0]        mag_re, mag_im;
    logic [NW-1:0]      num_re, num_im;
    logic [NW-QBITS-1:0] hi_re, hi_im;
    t_meta              n_meta;
    t_lane              n_lre, n_lim;

    always_comb begin
        if (r2_op == OP_MUL) begin
            v_re = r2_re >>> FRAC_BITS;
            v_im = r2_im >>> FRAC_BITS;
        end else begin
            v_re = r2_re;
            v_im = r2_im;
        end
        s_re   = sat66(v_re);
        s_im   = sat66(v_im);
        mag_re = r2_re[65] ? 64'(-r2_re) : r2_re[63:0];
        mag_im = r2_im[65] ? 64'(-r2_im) : r2_im[63:0];
        num_re = NW'(mag_re) << FRAC_BITS;
        num_im = NW'(mag_im) << FRAC_BITS;
        hi_re  = num_re[NW-1:QBITS];
        hi_im  = num_im[NW-1:QBITS];

        n_meta.op     = r2_op;
        n_meta.dz     = (r2_op == OP_DIV) && (r2_den == 64'd0);
        n_meta.pov_re = 64'(hi_re) >= r2_den;
        n_meta.pov_im = 64'(hi_im) >= r2_den;
        n_meta.neg_re = r2_re[65];
        n_meta.neg_im = r2_im[65];
        n_meta.res_re = s_re.val;
        n_meta.res_im = s_im.val;
        n_meta.ov     = s_re.ov | s_im.ov;

        n_lre.rem = 64'(hi_re);
        n_lre.low = num_re[QBITS-1:0];
        n_lre.quo = '0;
        n_lim.rem = 64'(hi_im);
        n_lim.low = num_im[QBITS-1:0];
        n_lim.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_meta <= n_meta;
            o_den  <= r2_den;
            o_re   <= n_lre;
            o_im   <= n_lim;
        end
    end

endmodule

// ===== hw/rtl/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell: one cell of the divider chain
// Produces one quotient bit for each lane and hands the transaction onward.
// ----------------------------------------------------------------------------
module cau_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cau_pkg::t_meta i_meta,
    input  logic [63:0]    i_den,
    input  cau_pkg::t_lane i_re,
    input  cau_pkg::t_lane i_im,
    output logic           o_valid,
    output cau_pkg::t_meta o_meta,
    output logic [63:0]    o_den,
    output cau_pkg::t_lane o_re,
    output cau_pkg::t_lane o_im
);
    import cau_pkg::*;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_meta <= i_meta;
            o_den  <= i_den;
            o_re   <= div_step(i_re, i_den);
            o_im   <= div_step(i_im, i_den);
        end
    end

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex add, subtract, multiply, divide in Q16.16
// Pipelined front end, chain of divider cells and a two-entry output buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_opcode and the four operand parts.
//   Output channel: o_valid / i_stall with o_res_re, o_res_im, o_overflow,
//   o_div_zero. A transaction moves when valid is high and stall is low.
//   Every opcode takes the same path, so results leave in input order.
//   Pipeline: 3 front stages, 33 divider cells, 1 output stage.
//   Throughput: one transaction per cycle while o_stall is low; the divider chain
//   yields one quotient bit per cell, so every cell stage holds its own transaction.
//   When the receiver stalls, results collect in a two-entry buffer; once it
//   is full the whole pipeline freezes and o_stall rises until a result is
//   taken. Reset empties the pipeline and the buffer; nothing else is held.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic               o_overflow,
    output logic               o_div_zero
);
    import cau_pkg::*;

    logic  en;
    logic  c_valid [0:QBITS];
    t_meta c_meta  [0:QBITS];
    logic [63:0] c_den [0:QBITS];
    t_lane c_re    [0:QBITS];
    t_lane c_im    [0:QBITS];

    logic [1:0] r_cnt;
    logic       r_wr, r_rd;
    t_result    r_buf [0:1];

    assign en      = (r_cnt != 2'd2);
    assign o_stall = !en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_valid  (c_valid[0]),
        .o_meta   (c_meta[0]),
        .o_den    (c_den[0]),
        .o_re     (c_re[0]),
        .o_im     (c_im[0])
    );

    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_meta  (c_meta[g]),
            .i_den   (c_den[g]),
            .i_re    (c_re[g]),
            .i_im    (c_im[g]),
            .o_valid (c_valid[g+1]),
            .o_meta  (c_meta[g+1]),
            .o_den   (c_den[g+1]),
            .o_re    (c_re[g+1]),
            .o_im    (c_im[g+1])
        );
    end

    // final result of the transaction leaving the last cell
    t_meta   last;
    t_sat    q_re, q_im;
    t_result n_res;
    logic    push, pop;

    always_comb begin
        last = c_meta[QBITS];
        q_re = qsat(last.neg_re, last.pov_re, c_re[QBITS].quo);
        q_im = qsat(last.neg_im, last.pov_im, c_im[QBITS].quo);
        if (last.op != OP_DIV) begin
            n_res.re = last.res_re;
            n_res.im = last.res_im;
            n_res.ov = last.ov;
            n_res.dz = 1'b0;
        end else if (last.dz) begin
            n_res.re = '0;
            n_res.im = '0;
            n_res.ov = 1'b0;
            n_res.dz = 1'b1;
        end else begin
            n_res.re = q_re.val;
            n_res.im = q_im.val;
            n_res.ov = q_re.ov | q_im.ov;
            n_res.dz = 1'b0;
        end
    end

    assign push = en && c_valid[QBITS];
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= n_res;
        end
    end

    assign o_valid    = (r_cnt != 2'd0);
    assign o_res_re   = r_buf[r_rd].re;
    assign o_res_im   = r_buf[r_rd].im;
    assign o_overflow = r_buf[r_rd].ov;
    assign o_div_zero = r_buf[r_rd].dz;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_cnt == $past(r_cnt) - 2'd1)
        else $error("output buffer count did not drop on a lone read");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_re == 32'sd0 && o_res_im == 32'sd0
                                  && !o_overflow)
        else $error("divide by zero result not cleared");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output buffer");
`endif

endmodule

// ===== test/cau_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cau_checker: result predictor and scoreboard for the complex arithmetic unit
// Watches both channels, computes the expected complex result of every
// accepted operand transaction and compares each result transaction in order.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_a_re,
    input  logic [31:0] i_a_im,
    input  logic [31:0] i_b_re,
    input  logic [31:0] i_b_im,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_res_re,
    input  logic [31:0] i_res_im,
    input  logic        i_overflow,
    input  logic        i_div_zero,
    output int          o_errors,
    output int          o_pending
);

    t_result expected_q[$];
    int      err_count  = 0;
    int      pend_count = 0;

    // saturate a wide signed value to 32 bits, flag on clip
    function automatic logic [31:0] clip32(input logic signed [131:0] v, inout logic ov);
        if (v > 132'sd2147483647) begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -132'sd2147483648) begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // scaled quotient truncated toward zero; magnitude capped like the hardware
    function automatic logic signed [131:0] scaled_quot(input logic signed [131:0] num,
                                                        input logic signed [131:0] den);
        logic signed [131:0] mag, q;
        logic                neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = (mag <<< FRAC_BITS) / den;
        if (q > (132'sd1 <<< 40)) q = 132'sd1 <<< 40;
        return neg ? -q : q;
    endfunction

    function automatic t_result complex_result(input logic [1:0] op,
            input logic signed [31:0] ar, input logic signed [31:0] ai,
            input logic signed [31:0] br, input logic signed [31:0] bi);
        t_result             r;
        logic signed [131:0] xr, xi, den;
        r = '0;
        case (op)
            OP_ADD: begin
                xr = 132'(ar) + 132'(br);
                xi = 132'(ai) + 132'(bi);
            end
            OP_SUB: begin
                xr = 132'(ar) - 132'(br);
                xi = 132'(ai) - 132'(bi);
            end
            OP_MUL: begin
                // arithmetic shift floors toward minus infinity
                xr = (132'(ar) * 132'(br) - 132'(ai) * 132'(bi)) >>> FRAC_BITS;
                xi = (132'(ar) * 132'(bi) + 132'(ai) * 132'(br)) >>> FRAC_BITS;
            end
            default: begin
                den = 132'(br) * 132'(br) + 132'(bi) * 132'(bi);
                if (den == 0) begin
                    r.dz = 1'b1;
                    return r;
                end
                xr = scaled_quot(132'(ar) * 132'(br) + 132'(ai) * 132'(bi), den);
                xi = scaled_quot(132'(ai) * 132'(br) - 132'(ar) * 132'(bi), den);
            end
        endcase
        r.re = clip32(xr, r.ov);
        r.im = clip32(xi, r.ov);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    assign o_errors  = err_count;
    assign o_pending = pend_count;

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            expected_q.push_back(complex_result(i_opcode, i_a_re, i_a_im, i_b_re, i_b_im));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", i_res_re, 32'h0);
            end else begin
                want = expected_q.pop_front();
                if (i_res_re !== want.re) report_mismatch("res_re", i_res_re, want.re);
                if (i_res_im !== want.im) report_mismatch("res_im", i_res_im, want.im);
                if (i_overflow !== want.ov)
                    report_mismatch("overflow", 32'(i_overflow), 32'(want.ov));
                if (i_div_zero !== want.dz)
                    report_mismatch("div_zero", 32'(i_div_zero), 32'(want.dz));
            end
        end
        pend_count = expected_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the complex arithmetic unit
// Directed corner operands, then random add/sub/mul/div transactions with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
    import cau_pkg::*;

    localparam int N_RANDOM  = 400;
    localparam int LATENCY   = 37;
    localparam int MAX_CYCLE = 200000;

    logic        i_clk, i_rst_n, i_valid;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_overflow, o_div_zero;
    logic [1:0]  i_opcode;
    logic [31:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic [31:0] o_res_re, o_res_im;
    int          errors, pending;
    int          cycles = 0;
    bit          calm_in, calm_out;

    complex_arithmetic_unit i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode,
        .i_a_re, .i_a_im, .i_b_re, .i_b_im,
        .o_valid, .i_stall, .o_res_re, .o_res_im, .o_overflow, .o_div_zero
    );

    cau_checker i_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_opcode,
        .i_a_re, .i_a_im, .i_b_re, .i_b_im,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_res_re(o_res_re), .i_res_im(o_res_im),
        .i_overflow(o_overflow), .i_div_zero(o_div_zero),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver stalls at random except during the calm stretch
    always @(negedge i_clk)
        i_stall <= i_rst_n && !calm_out && ($urandom_range(99) < 22);

    function automatic logic [31:0] pick_part();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(8'hFF)) - 128) <<< 16;
            4: return 32'(signed'($urandom_range(20'hFFFFF)) - 32'sd524288);
            default: return $urandom();
        endcase
    endfunction

    // present one transaction, holding it until accepted
    task automatic send_op(input logic [1:0] op, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
        while (!calm_in && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_a_re   <= ar;
        i_a_im   <= ai;
        i_b_re   <= br;
        i_b_im   <= bi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [1:0]  op;
        logic [31:0] br, bi;
        calm_in  = 1'b0;
        calm_out = 1'b0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_opcode = OP_ADD;
        {i_a_re, i_a_im, i_b_re, i_b_im} = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 4; k++) begin
            op = 2'(k);
            send_op(op, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            send_op(op, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
            send_op(op, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001, 32'hFFFF_FFFF);
            send_op(op, 32'h0003_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
            send_op(op, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0001_0000);
        end
        send_op(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
        send_op(OP_DIV, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm_in  = (n >= 150 && n < 220);
            calm_out = calm_in;
            op = 2'($urandom_range(3));
            br = pick_part();
            bi = pick_part();
            // some divides by zero magnitude
            if (op == OP_DIV && $urandom_range(9) == 0) begin
                br = '0;
                bi = '0;
            end
            send_op(op, pick_part(), pick_part(), br, bi);
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_cell.sv
hw/rtl/complex_arithmetic_unit.sv
test/cau_checker.sv
test/testbench.sv
